// ===== rtl/bts_pkg.sv =====
// Shared types and constants for the byte translate/delete/squeeze filter.
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;

	localparam int unsigned SYMBOL_BITS_DEFAULT = 8;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COMPLEMENT = 2'd0,
		CFG_DELETE     = 2'd1,
		CFG_SQUEEZE    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_LOAD = 1'b1
	} mode_t;

	typedef struct packed {
		logic complement_on;
		logic delete_on;
		logic squeeze_on;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/bts_front.sv =====
// Front end: table memory, clearing pass, lookup, translate and delete decision.
`timescale 1ns / 1ps
`default_nettype none
module bts_front
	import bts_pkg::*;
#(
	parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   push,
	input  wire logic                   mode,
	input  wire logic [SYMBOL_BITS-1:0] data_byte,
	input  wire logic [SYMBOL_BITS-1:0] entry_map,
	input  wire logic                   entry_in_set,
	input  wire logic                   entry_squeeze,
	input  wire logic [QUEUE_LVL_W-1:0] q_level,
	output logic                        full,
	output logic                        clr_busy,
	output logic                        q_push,
	output logic [SYMBOL_BITS-1:0]      q_sym,
	output logic                        q_sq
);

	localparam int unsigned DEPTH = 1 << SYMBOL_BITS;
	localparam int unsigned ROW_W = SYMBOL_BITS + 2;

	logic [ROW_W-1:0] mem [DEPTH];

	logic                   clr_busy_q;
	logic [SYMBOL_BITS-1:0] clr_idx_q;

	logic                   accept;
	logic                   wr_en;
	logic [SYMBOL_BITS-1:0] wr_addr;
	logic [ROW_W-1:0]       wr_row;

	logic                   act_s1;
	logic [SYMBOL_BITS-1:0] sym_s1;
	logic [ROW_W-1:0]       row_s1;

	logic                   member;
	logic                   keep;
	logic [SYMBOL_BITS-1:0] tsym;

	logic                   act_s2;
	logic [SYMBOL_BITS-1:0] sym_s2;
	logic [ROW_W-1:0]       row_s2;

	logic [QUEUE_LVL_W-1:0] credit_used;

	assign credit_used = q_level + QUEUE_LVL_W'(act_s1) + QUEUE_LVL_W'(act_s2);
	assign full        = clr_busy_q || (credit_used >= QUEUE_LVL_W'(QUEUE_DEPTH));
	assign clr_busy    = clr_busy_q;
	assign accept      = push && !full;

	always_comb begin
		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_row  = {clr_idx_q, 2'b00};
		end else begin
			wr_en   = accept && (mode == MODE_LOAD);
			wr_addr = data_byte;
			wr_row  = {entry_map, entry_in_set, entry_squeeze};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {SYMBOL_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= mem[data_byte];
		sym_s1 <= data_byte;
	end

	assign member = row_s1[1] ^ cfg.complement_on;
	assign keep   = !(cfg.delete_on && member);
	assign tsym   = (!cfg.delete_on && member) ? row_s1[ROW_W-1:2] : sym_s1;

	always_ff @(posedge clk) begin
		row_s2 <= mem[tsym];
		sym_s2 <= tsym;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= accept && (mode == MODE_DATA);
			act_s2 <= act_s1 && keep;
		end
	end

	assign q_push = act_s2;
	assign q_sym  = sym_s2;
	assign q_sq   = row_s2[0];

endmodule
`default_nettype wire

// ===== rtl/bts_queue.sv =====
// Short queue between the front end and the squeeze stage.
`timescale 1ns / 1ps
`default_nettype none
module bts_queue
	import bts_pkg::*;
#(
	parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr,
	input  wire logic [SYMBOL_BITS-1:0] wr_sym,
	input  wire logic                   wr_sq,
	input  wire logic                   rd,
	output logic                        head_valid,
	output logic [SYMBOL_BITS-1:0]      head_sym,
	output logic                        head_sq,
	output logic [QUEUE_LVL_W-1:0]      level
);

	logic [SYMBOL_BITS-1:0] sym_q [QUEUE_DEPTH];
	logic                   sq_q  [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wptr_q;
	logic [QUEUE_PTR_W-1:0] rptr_q;
	logic [QUEUE_LVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			sym_q[wptr_q] <= wr_sym;
			sq_q[wptr_q]  <= wr_sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			level_q <= level_q + QUEUE_LVL_W'(wr) - QUEUE_LVL_W'(rd);
		end
	end

	assign head_valid = (level_q != '0);
	assign head_sym   = sym_q[rptr_q];
	assign head_sq    = sq_q[rptr_q];
	assign level      = level_q;

endmodule
`default_nettype wire

// ===== rtl/bts_back.sv =====
// Back end: squeeze of repeated symbols and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bts_back
	import bts_pkg::*;
#(
	parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   head_valid,
	input  wire logic [SYMBOL_BITS-1:0] head_sym,
	input  wire logic                   head_sq,
	output logic                        deq,
	input  wire logic                   pop,
	output logic                        empty,
	output logic [SYMBOL_BITS-1:0]      out_byte
);

	logic                   out_valid_q;
	logic [SYMBOL_BITS-1:0] out_byte_q;
	logic [SYMBOL_BITS-1:0] last_q;
	logic                   last_valid_q;

	logic in_sq_set;
	logic drop;
	logic slot_free;

	assign in_sq_set = cfg.squeeze_on && head_sq;
	assign drop      = in_sq_set && last_valid_q && (last_q == head_sym);
	assign slot_free = !out_valid_q || pop;
	assign deq       = head_valid && (drop || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			last_q       <= '0;
			last_valid_q <= 1'b0;
		end else begin
			if (deq && !drop) begin
				out_valid_q  <= 1'b1;
				last_valid_q <= in_sq_set;
				if (in_sq_set) begin
					last_q <= head_sym;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deq && !drop) begin
			out_byte_q <= head_sym;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;

endmodule
`default_nettype wire

// ===== rtl/byte_translate_delete_squeeze_core.sv =====
// Top level of the byte translate/delete/squeeze filter.
//
// Input side is a queue write port: a beat is taken when push is high and full
// is low. mode selects a table load (data_byte is the index, entry_* the row)
// or a data byte. Loads give no result; a data byte gives zero or one result.
// Result side is a queue read port: out_byte is valid while empty is low and
// the beat is taken when pop is high.
// Configuration registers (complement, delete, squeeze) are written through
// cfg_wr_en / cfg_index / cfg_data; write them only while idle.
// Throughput is one beat per cycle while full is low. A kept data byte passes
// two table reads (source row, then the squeeze bit of the translated byte),
// the middle queue and one squeeze stage feeding the result register.
// After reset the table is cleared to identity by a pass over all
// 2**SYMBOL_BITS entries (256 by default); full stays high during that pass.
// When pop is held low the result register and the four-entry middle queue
// fill up and full rises; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module byte_translate_delete_squeeze_core
	import bts_pkg::*;
#(
	parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   mode,
	input  wire logic [SYMBOL_BITS-1:0] data_byte,
	input  wire logic [SYMBOL_BITS-1:0] entry_map,
	input  wire logic                   entry_in_set,
	input  wire logic                   entry_squeeze,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [SYMBOL_BITS-1:0]      out_byte
);

	cfg_t cfg_q;

	logic                   clr_busy;
	logic                   q_push;
	logic [SYMBOL_BITS-1:0] q_sym;
	logic                   q_sq;
	logic                   q_pop;
	logic                   head_valid;
	logic [SYMBOL_BITS-1:0] head_sym;
	logic                   head_sq;
	logic [QUEUE_LVL_W-1:0] q_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_COMPLEMENT: cfg_q.complement_on <= cfg_data[0];
				CFG_DELETE:     cfg_q.delete_on     <= cfg_data[0];
				CFG_SQUEEZE:    cfg_q.squeeze_on    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	bts_front #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.mode         (mode),
		.data_byte    (data_byte),
		.entry_map    (entry_map),
		.entry_in_set (entry_in_set),
		.entry_squeeze(entry_squeeze),
		.q_level      (q_level),
		.full         (full),
		.clr_busy     (clr_busy),
		.q_push       (q_push),
		.q_sym        (q_sym),
		.q_sq         (q_sq)
	);

	bts_queue #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_push),
		.wr_sym    (q_sym),
		.wr_sq     (q_sq),
		.rd        (q_pop),
		.head_valid(head_valid),
		.head_sym  (head_sym),
		.head_sq   (head_sq),
		.level     (q_level)
	);

	bts_back #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head_sym  (head_sym),
		.head_sq   (head_sq),
		.deq       (q_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |-> (q_level < QUEUE_LVL_W'(QUEUE_DEPTH)))
		else $error("middle queue written while full");

	a_queue_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head_valid)
		else $error("middle queue read while empty");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> (full && !q_push))
		else $error("beat taken during table clearing pass");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result lost without pop");

endmodule
`default_nettype wire

// ===== bench/byte_translate_delete_squeeze_core_test.sv =====
// Self-checking testbench for the byte translate/delete/squeeze filter core.
`timescale 1ns / 1ps
module byte_translate_delete_squeeze_core_test;
	import bts_pkg::*;

	localparam int SYM_W = SYMBOL_BITS_DEFAULT;
	localparam int SYM_COUNT = 2 ** SYM_W;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
	localparam int DRAIN_LIMIT = 20000;
	localparam int QUIET_CYCLES = 8;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct {
		mode_t            mode;
		logic [SYM_W-1:0] data_byte;
		logic [SYM_W-1:0] entry_map;
		logic             entry_in_set;
		logic             entry_squeeze;
	} tr_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   push = 1'b0;
	logic                   full;
	logic                   mode = 1'b0;
	logic [SYM_W-1:0]       data_byte = '0;
	logic [SYM_W-1:0]       entry_map = '0;
	logic                   entry_in_set = 1'b0;
	logic                   entry_squeeze = 1'b0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [SYM_W-1:0]       out_byte;

	byte_translate_delete_squeeze_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.mode(mode),
		.data_byte(data_byte),
		.entry_map(entry_map),
		.entry_in_set(entry_in_set),
		.entry_squeeze(entry_squeeze),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte)
	);

	// bench copy of the filter state
	logic [SYM_W-1:0] subst_map [SYM_COUNT];
	logic             src_set [SYM_COUNT];
	logic             sq_set [SYM_COUNT];
	logic [SYM_W-1:0] run_byte;
	logic             run_valid;
	logic             cfg_complement;
	logic             cfg_delete;
	logic             cfg_squeeze;

	tr_beat_t         beats_pending [$];
	logic [SYM_W-1:0] bytes_due [$];
	tr_beat_t         drive_beat;
	logic [SYM_W-1:0] due_byte;
	logic             in_taken = 1'b0;
	int               in_gap = 0;
	int               out_gap = 0;
	int               in_odds = 0;
	int               out_odds = 0;
	int               fail_count = 0;

	function automatic void note_failure(string msg);
		if (fail_count < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endfunction

	function automatic void translate_squeeze(tr_beat_t b);
		logic [SYM_W-1:0] sym;
		logic             member;
		if (b.mode == MODE_LOAD) begin
			subst_map[b.data_byte] = b.entry_map;
			src_set[b.data_byte] = b.entry_in_set;
			sq_set[b.data_byte] = b.entry_squeeze;
			return;
		end
		sym = b.data_byte;
		member = src_set[sym] ^ cfg_complement;
		if (cfg_delete && member)
			return;
		if (!cfg_delete && member)
			sym = subst_map[sym];
		if (cfg_squeeze && sq_set[sym]) begin
			if (run_valid && run_byte == sym)
				return;
			run_byte = sym;
			run_valid = 1'b1;
		end else begin
			run_valid = 1'b0;
		end
		bytes_due.push_back(sym);
	endfunction

	function automatic tr_beat_t data_beat(logic [SYM_W-1:0] b);
		tr_beat_t t;
		t.mode = MODE_DATA;
		t.data_byte = b;
		t.entry_map = SYM_W'($urandom_range(0, SYM_COUNT - 1));
		t.entry_in_set = 1'($urandom_range(0, 1));
		t.entry_squeeze = 1'($urandom_range(0, 1));
		return t;
	endfunction

	function automatic tr_beat_t load_beat(logic [SYM_W-1:0] idx, logic [SYM_W-1:0] map,
			logic in_set, logic sq);
		tr_beat_t t;
		t.mode = MODE_LOAD;
		t.data_byte = idx;
		t.entry_map = map;
		t.entry_in_set = in_set;
		t.entry_squeeze = sq;
		return t;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// input side: hold the beat until taken, then advance
	always @(negedge clk) begin
		if (arst_n && (!push || in_taken)) begin
			if (in_gap == 0 && in_odds != 0 && $urandom_range(1, in_odds) == 1)
				in_gap = $urandom_range(1, 12);
			if (in_gap != 0) begin
				in_gap--;
				push <= 1'b0;
			end else if (beats_pending.size() != 0) begin
				drive_beat = beats_pending.pop_front();
				push <= 1'b1;
				mode <= drive_beat.mode;
				data_byte <= drive_beat.data_byte;
				entry_map <= drive_beat.entry_map;
				entry_in_set <= drive_beat.entry_in_set;
				entry_squeeze <= drive_beat.entry_squeeze;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side: stall in bursts
	always @(negedge clk) begin
		if (out_gap == 0 && out_odds != 0 && $urandom_range(1, out_odds) == 1)
			out_gap = $urandom_range(1, 12);
		if (out_gap != 0) begin
			out_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= push && !full;
			if (push && !full)
				translate_squeeze(mode == MODE_LOAD ?
					load_beat(data_byte, entry_map, entry_in_set, entry_squeeze) :
					data_beat(data_byte));
			if (pop && !empty) begin
				if (bytes_due.size() == 0) begin
					note_failure($sformatf("out_byte %02h, expected none", out_byte));
				end else begin
					due_byte = bytes_due.pop_front();
					if (out_byte !== due_byte)
						note_failure($sformatf("out_byte %02h, expected %02h", out_byte,
							due_byte));
				end
			end
		end
	end

	task automatic drain();
		int waited;
		int quiet;
		waited = 0;
		quiet = 0;
		while (quiet < QUIET_CYCLES && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
			if (beats_pending.size() == 0 && !push && bytes_due.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
		repeat (6) @(negedge clk);
		if (bytes_due.size() != 0) begin
			note_failure($sformatf("%0d beats never arrived, next expected %02h",
				bytes_due.size(), bytes_due[0]));
			bytes_due.delete();
		end
	endtask

	task automatic start_phase(logic c, logic d, logic s, int odds);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_COMPLEMENT;
		cfg_data <= c;
		cfg_complement = c;
		@(negedge clk);
		cfg_index <= CFG_DELETE;
		cfg_data <= d;
		cfg_delete = d;
		@(negedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= 1'($urandom_range(0, 1));
		@(negedge clk);
		cfg_index <= CFG_SQUEEZE;
		cfg_data <= s;
		cfg_squeeze = s;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		in_odds = odds;
		out_odds = odds;
	endtask

	task automatic random_phase(int n);
		logic [SYM_W-1:0] hot [8];
		logic [SYM_W-1:0] last_sym;
		int               i;
		int               pick;
		for (i = 0; i < 8; i++)
			hot[i] = SYM_W'($urandom_range(0, SYM_COUNT - 1));
		for (i = 0; i < 8; i++)
			beats_pending.push_back(load_beat(hot[i], hot[$urandom_range(0, 7)],
				1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0));
		last_sym = hot[0];
		for (i = 8; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				beats_pending.push_back(load_beat(
					pick < 6 ? hot[$urandom_range(0, 7)] : SYM_W'($urandom_range(0, SYM_COUNT - 1)),
					pick < 9 ? hot[$urandom_range(0, 7)] : SYM_W'($urandom_range(0, SYM_COUNT - 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end else begin
				if (pick >= 85)
					last_sym = SYM_W'($urandom_range(0, SYM_COUNT - 1));
				else if (pick >= 45)
					last_sym = hot[$urandom_range(0, 7)];
				beats_pending.push_back(data_beat(last_sym));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_COMPLEMENT;
		cfg_data = '0;
		for (int i = 0; i < SYM_COUNT; i++) begin
			subst_map[i] = SYM_W'(i);
			src_set[i] = 1'b0;
			sq_set[i] = 1'b0;
		end
		run_byte = '0;
		run_valid = 1'b0;
		cfg_complement = 1'b0;
		cfg_delete = 1'b0;
		cfg_squeeze = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (full)
			@(negedge clk);

		start_phase(1'b0, 1'b0, 1'b0, 6);
		beats_pending.push_back(data_beat(8'h00));
		beats_pending.push_back(data_beat(8'hff));
		beats_pending.push_back(load_beat(8'h00, 8'hff, 1'b1, 1'b1));
		beats_pending.push_back(load_beat(8'hff, 8'h00, 1'b1, 1'b0));
		beats_pending.push_back(load_beat(8'h41, 8'h42, 1'b1, 1'b1));
		beats_pending.push_back(load_beat(8'h42, 8'h42, 1'b0, 1'b1));
		beats_pending.push_back(data_beat(8'h00));
		beats_pending.push_back(data_beat(8'hff));
		beats_pending.push_back(data_beat(8'h41));

		start_phase(1'b0, 1'b0, 1'b1, 6);
		beats_pending.push_back(data_beat(8'h42));
		beats_pending.push_back(data_beat(8'h41));
		beats_pending.push_back(data_beat(8'h42));
		beats_pending.push_back(data_beat(8'h10));
		beats_pending.push_back(data_beat(8'h42));
		beats_pending.push_back(load_beat(8'h10, 8'h10, 1'b0, 1'b0));
		beats_pending.push_back(data_beat(8'h42));

		start_phase(1'b0, 1'b1, 1'b1, 6);
		beats_pending.push_back(data_beat(8'h41));
		beats_pending.push_back(data_beat(8'h42));
		beats_pending.push_back(data_beat(8'h41));
		beats_pending.push_back(data_beat(8'h42));

		start_phase(1'b1, 1'b0, 1'b0, 6);
		beats_pending.push_back(data_beat(8'h42));
		beats_pending.push_back(data_beat(8'h41));
		beats_pending.push_back(data_beat(8'h05));

		start_phase(1'b1, 1'b1, 1'b0, 6);
		beats_pending.push_back(data_beat(8'h05));
		beats_pending.push_back(data_beat(8'h41));

		for (int k = 0; k < 8; k++) begin
			start_phase(k[2], k[1], k[0], k == 7 ? 0 : 4 * $urandom_range(0, 2));
			random_phase(235);
		end

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(CYCLE_LIMIT * 10);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
